### design/assert_macros.svh
// assertion macros shared by the nearest point table rtl
// expects i_clk and i_rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define NPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define NPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/npt_pkg.sv
// types and constants of the nearest point table
// no dependencies; used by every module of the block
package npt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int REQ_W       = 2;
    localparam int COORD_W     = 16;
    localparam int LABEL_W     = 16;
    localparam int SLOT_W      = 10;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = 34;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [DIST_W-1:0] DIST_MAX  = 34'd12884508675;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [LABEL_W-1:0]        label_tag;
    } t_req;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   slot;
        logic [LABEL_W-1:0]  slot_label;
        logic [DIST_W-1:0]   dist_sq;
    } t_rsp;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_x;
    } t_point;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        t_point             pt;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_cmd;

    typedef struct packed {
        logic              entry_en;
        logic              used_en;
        logic              used_val;
        logic [ADDR_W-1:0] addr;
        t_entry            entry;
    } t_wr_cmd;

    typedef struct packed {
        logic               vld;
        logic               used;
        logic [ADDR_W-1:0]  addr;
        logic [LABEL_W-1:0] label;
    } t_tag;

endpackage

### design/npt_table.sv
// point table storage: entry memory and used-mark memory
// one write port, one registered read port each; depends on npt_pkg
module npt_table (
    input  logic             i_clk,
    input  npt_pkg::t_rd_cmd i_rd,
    input  npt_pkg::t_wr_cmd i_wr,
    output npt_pkg::t_entry  o_rd_entry,
    output logic             o_rd_used
);

    npt_pkg::t_entry r_entry_mem [npt_pkg::TABLE_DEPTH];
    logic            r_used_mem  [npt_pkg::TABLE_DEPTH];
    npt_pkg::t_entry r_rd_entry;
    logic            r_rd_used;

    always_ff @(posedge i_clk) begin
        if (i_wr.entry_en) begin
            r_entry_mem[i_wr.addr] <= i_wr.entry;
        end
        if (i_wr.used_en) begin
            r_used_mem[i_wr.addr] <= i_wr.used_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_entry <= r_entry_mem[i_rd.addr];
            r_rd_used  <= r_used_mem[i_rd.addr];
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_used  = r_rd_used;

endmodule

### design/npt_dist.sv
// pipelined squared-distance unit: difference, square, sum stages
// shared by every entry of a scan; depends on npt_pkg and assert_macros.svh
`include "assert_macros.svh"

module npt_dist (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  npt_pkg::t_point                i_qry,
    input  npt_pkg::t_point                i_pt,
    input  npt_pkg::t_tag                  i_tag,
    output logic [npt_pkg::DIST_W-1:0]     o_dist,
    output npt_pkg::t_tag                  o_tag
);

    localparam int DIFF_W = npt_pkg::DIFF_W;
    localparam int PROD_W = npt_pkg::PROD_W;
    localparam int SQ_W   = npt_pkg::SQ_W;
    localparam int DIST_W = npt_pkg::DIST_W;

    logic signed [DIFF_W-1:0] w_dx, w_dy, w_dz;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic signed [PROD_W-1:0] w_px, w_py, w_pz;
    logic [SQ_W-1:0]          r_sx, r_sy, r_sz;
    logic [DIST_W-1:0]        r_sum;
    npt_pkg::t_tag            r_tag1, r_tag2, r_tag3;

    assign w_dx = DIFF_W'(i_qry.pos_x) - DIFF_W'(i_pt.pos_x);
    assign w_dy = DIFF_W'(i_qry.pos_y) - DIFF_W'(i_pt.pos_y);
    assign w_dz = DIFF_W'(i_qry.pos_z) - DIFF_W'(i_pt.pos_z);

    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_pz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
        r_dx  <= w_dx;
        r_dy  <= w_dy;
        r_dz  <= w_dz;
        r_sx  <= w_px[SQ_W-1:0];
        r_sy  <= w_py[SQ_W-1:0];
        r_sz  <= w_pz[SQ_W-1:0];
        r_sum <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
    end

    assign o_dist = r_sum;
    assign o_tag  = r_tag3;

    `NPT_ASSERT_IMP(a_dist_range, r_tag3.vld && r_tag3.used,
        r_sum <= npt_pkg::DIST_MAX, "distance beyond three squared axis spans")

endmodule

### design/nearest_point_table_unit.sv
// nearest point table top level: request sequencer, best-match tracking, result register
// depends on npt_pkg, npt_table, npt_dist and assert_macros.svh
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-------------------------
//  request | i_in_valid  | o_in_ready  | i_req  (npt_pkg::t_req)
//  result  | o_out_valid | i_out_ready | o_rsp  (npt_pkg::t_rsp)
//
// add: the slot is found by the used-mark search (one slot read per cycle)
// delete / query: one entry read per cycle through the distance pipeline
// after reset a clearing pass zeroes the used marks; no request is taken
// one request at a time; the next is taken while the previous result waits in o_rsp
// a stalled result holds the sequencer in its final state until the result register frees
`include "assert_macros.svh"

module nearest_point_table_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  npt_pkg::t_req i_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output npt_pkg::t_rsp o_rsp
);

    localparam int ADDR_W  = npt_pkg::ADDR_W;
    localparam int SLOT_W  = npt_pkg::SLOT_W;
    localparam int LABEL_W = npt_pkg::LABEL_W;
    localparam int DIST_W  = npt_pkg::DIST_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic                 r_issue, n_issue;
    npt_pkg::t_req        r_req, n_req;
    logic                 r_have, n_have;
    logic [ADDR_W-1:0]    r_best_addr, n_best_addr;
    logic [LABEL_W-1:0]   r_best_label, n_best_label;
    logic [DIST_W-1:0]    r_best_dist, n_best_dist;
    npt_pkg::t_rsp        r_res, n_res;
    npt_pkg::t_rsp        r_out, n_out;
    logic                 r_out_valid, n_out_valid;
    logic                 r_p1_vld;
    logic [ADDR_W-1:0]    r_p1_addr;

    npt_pkg::t_rd_cmd     w_rd;
    npt_pkg::t_wr_cmd     w_wr;
    npt_pkg::t_entry      w_rd_entry;
    logic                 w_rd_used;
    npt_pkg::t_point      w_qry;
    npt_pkg::t_tag        w_in_tag;
    npt_pkg::t_tag        w_dtag;
    logic [DIST_W-1:0]    w_dist;
    logic                 w_better;

    npt_table u_table (
        .i_clk      (i_clk),
        .i_rd       (w_rd),
        .i_wr       (w_wr),
        .o_rd_entry (w_rd_entry),
        .o_rd_used  (w_rd_used)
    );

    assign w_qry.pos_x = r_req.pos_x;
    assign w_qry.pos_y = r_req.pos_y;
    assign w_qry.pos_z = r_req.pos_z;

    assign w_in_tag.vld   = r_p1_vld && (r_state == S_SCAN);
    assign w_in_tag.used  = w_rd_used;
    assign w_in_tag.addr  = r_p1_addr;
    assign w_in_tag.label = w_rd_entry.label;

    npt_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qry   (w_qry),
        .i_pt    (w_rd_entry.pt),
        .i_tag   (w_in_tag),
        .o_dist  (w_dist),
        .o_tag   (w_dtag)
    );

    assign w_better = w_dtag.vld && w_dtag.used && (!r_have || (w_dist < r_best_dist));

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue      = r_issue;
        n_req        = r_req;
        n_have       = r_have;
        n_best_addr  = r_best_addr;
        n_best_label = r_best_label;
        n_best_dist  = r_best_dist;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        w_rd.en      = r_issue;
        w_rd.addr    = r_addr;
        w_wr         = '0;

        if (r_issue) begin
            if (r_addr == npt_pkg::LAST_ADDR) begin
                n_issue = 1'b0;
            end else begin
                n_addr = r_addr + ADDR_W'(1);
            end
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_wr.used_en  = 1'b1;
                w_wr.used_val = 1'b0;
                w_wr.addr     = r_addr;
                if (r_addr == npt_pkg::LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_req;
                    n_addr  = '0;
                    n_issue = 1'b1;
                    n_have  = 1'b0;
                    n_state = (i_req.req_type == npt_pkg::REQ_ADD) ? S_ADD : S_SCAN;
                end
            end
            S_ADD: begin
                if (r_p1_vld && (!w_rd_used || (r_p1_addr == npt_pkg::LAST_ADDR))) begin
                    w_wr.entry_en        = 1'b1;
                    w_wr.used_en         = 1'b1;
                    w_wr.used_val        = 1'b1;
                    w_wr.addr            = r_p1_addr;
                    w_wr.entry.label     = r_req.label_tag;
                    w_wr.entry.pt.pos_x  = r_req.pos_x;
                    w_wr.entry.pt.pos_y  = r_req.pos_y;
                    w_wr.entry.pt.pos_z  = r_req.pos_z;
                    n_res.found          = 1'b1;
                    n_res.slot           = SLOT_W'(r_p1_addr);
                    n_res.slot_label     = r_req.label_tag;
                    n_res.dist_sq        = '0;
                    n_issue              = 1'b0;
                    n_state              = S_DONE;
                end
            end
            S_SCAN: begin
                if (w_better) begin
                    n_have       = 1'b1;
                    n_best_addr  = w_dtag.addr;
                    n_best_label = w_dtag.label;
                    n_best_dist  = w_dist;
                end
                if (w_dtag.vld && (w_dtag.addr == npt_pkg::LAST_ADDR)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (r_have) begin
                    n_res.found      = 1'b1;
                    n_res.slot       = SLOT_W'(r_best_addr);
                    n_res.slot_label = r_best_label;
                    n_res.dist_sq    = r_best_dist;
                    if (r_req.req_type == npt_pkg::REQ_DELETE) begin
                        w_wr.used_en  = 1'b1;
                        w_wr.used_val = 1'b0;
                        w_wr.addr     = r_best_addr;
                    end
                end else begin
                    n_res = '0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_p1_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            r_p1_vld    <= r_issue;
        end
        r_req        <= n_req;
        r_best_addr  <= n_best_addr;
        r_best_label <= n_best_label;
        r_best_dist  <= n_best_dist;
        r_res        <= n_res;
        r_out        <= n_out;
        r_p1_addr    <= r_addr;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_out;

    `NPT_ASSERT_IMP(a_no_rw_collision, w_rd.en && w_wr.used_en,
        w_rd.addr != w_wr.addr, "table read and write hit the same slot")
    `NPT_ASSERT_IMP(a_scan_drained, r_state == S_FINISH,
        !r_issue && !r_p1_vld, "scan finished with reads still in flight")
    `NPT_ASSERT_NXT(a_add_result, r_state == S_ADD && w_wr.entry_en,
        r_res.found && (r_res.dist_sq == '0), "add result not marked found with zero distance")

endmodule

### tb/tb_nearest_point_table_unit.sv
// testbench for nearest_point_table_unit: directed table rows, then random add/delete/query/spare
// traffic with random idling and a quiet tail; results checked against staged values or a local predictor
// depends on npt_pkg and the nearest_point_table_unit rtl
module tb_nearest_point_table_unit;
    import npt_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 560;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_stim_row;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_req    = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_rsp out_rsp;

    bit          tbl_used [TABLE_DEPTH];
    t_entry      tbl_entry[TABLE_DEPTH];
    t_rsp        pending_rsp[$];
    t_stim_row   dir_rows[$];
    t_point      seen_points[$];
    int          mismatches = 0;
    int unsigned out_hold   = 0;
    bit          calm       = 1'b0;

    nearest_point_table_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_req      (in_req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_rsp      (out_rsp)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // generous bound on the whole run
    initial begin
        #(64'd120_000_000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_rsp rsp_of(logic found, logic [SLOT_W-1:0] slot,
                                    logic [LABEL_W-1:0] lab, logic [DIST_W-1:0] dsq);
        t_rsp rsp;
        rsp.found      = found;
        rsp.slot       = slot;
        rsp.slot_label = lab;
        rsp.dist_sq    = dsq;
        return rsp;
    endfunction

    function automatic void stage_row(logic [REQ_W-1:0] kind, logic [COORD_W-1:0] x,
                                      logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                                      logic [LABEL_W-1:0] lab, bit typed, t_rsp rsp);
        t_stim_row row;
        row.req.req_type  = kind;
        row.req.pos_x     = x;
        row.req.pos_y     = y;
        row.req.pos_z     = z;
        row.req.label_tag = lab;
        row.typed         = typed;
        row.rsp           = rsp;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [DIST_W-1:0] point_dist(t_point a, t_point b);
        longint dx, dy, dz;
        dx = longint'(a.pos_x) - longint'(b.pos_x);
        dy = longint'(a.pos_y) - longint'(b.pos_y);
        dz = longint'(a.pos_z) - longint'(b.pos_z);
        return DIST_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic t_rsp apply_request(t_req r);
        t_rsp              rsp;
        t_point            q;
        int                i, hit;
        logic [DIST_W-1:0] d, best;
        rsp     = '0;
        q.pos_x = r.pos_x;
        q.pos_y = r.pos_y;
        q.pos_z = r.pos_z;
        if (r.req_type == REQ_ADD) begin
            // lowest free slot, last slot when full
            hit = TABLE_DEPTH - 1;
            for (i = TABLE_DEPTH - 1; i >= 0; i--)
                if (!tbl_used[i]) hit = i;
            tbl_used[hit]        = 1'b1;
            tbl_entry[hit].pt    = q;
            tbl_entry[hit].label = r.label_tag;
            return rsp_of(1'b1, SLOT_W'(hit), r.label_tag, '0);
        end
        hit  = -1;
        best = '0;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_used[i]) begin
                d = point_dist(q, tbl_entry[i].pt);
                if (hit < 0 || d < best) begin
                    hit  = i;
                    best = d;
                end
            end
        end
        if (hit < 0) return rsp;
        if (r.req_type == REQ_DELETE) tbl_used[hit] = 1'b0;
        return rsp_of(1'b1, SLOT_W'(hit), tbl_entry[hit].label, best);
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3, 4: return COORD_W'($urandom_range(0, 16)) - COORD_W'(8);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic t_req random_request();
        t_req        r;
        t_point      p;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) r.req_type = REQ_ADD;
        else if (pick < 70) r.req_type = REQ_QUERY;
        else if (pick < 92) r.req_type = REQ_DELETE;
        else r.req_type = REQ_SPARE;
        // reuse a known point now and then to get exact hits and ties
        if (seen_points.size() != 0 && $urandom_range(0, 2) == 0) begin
            p = seen_points[$urandom_range(0, seen_points.size() - 1)];
            if ($urandom_range(0, 1) == 1) p.pos_y = p.pos_y + 16'sd1;
        end else begin
            p.pos_x = random_coord();
            p.pos_y = random_coord();
            p.pos_z = random_coord();
        end
        r.pos_x     = p.pos_x;
        r.pos_y     = p.pos_y;
        r.pos_z     = p.pos_z;
        r.label_tag = LABEL_W'($urandom);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_response(t_rsp got);
        t_rsp want;
        if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(got), '0);
            return;
        end
        want = pending_rsp.pop_front();
        if (got.found !== want.found) report_mismatch("found", 64'(got.found), 64'(want.found));
        if (got.slot !== want.slot) report_mismatch("slot", 64'(got.slot), 64'(want.slot));
        if (got.slot_label !== want.slot_label)
            report_mismatch("slot_label", 64'(got.slot_label), 64'(want.slot_label));
        if (got.dist_sq !== want.dist_sq)
            report_mismatch("dist_sq", 64'(got.dist_sq), 64'(want.dist_sq));
    endtask

    task automatic send_req(t_req r, bit typed, t_rsp typed_rsp);
        t_rsp   model_rsp;
        t_point p;
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (!in_ready);
        model_rsp = apply_request(r);
        pending_rsp.push_back(typed ? typed_rsp : model_rsp);
        if (r.req_type == REQ_ADD) begin
            p.pos_x = r.pos_x;
            p.pos_y = r.pos_y;
            p.pos_z = r.pos_z;
            seen_points.push_back(p);
            if (seen_points.size() > 48) void'(seen_points.pop_front());
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_rsp.size() != 0);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) check_response(out_rsp);
        if (out_hold != 0) begin
            out_hold = out_hold - 1;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            out_hold = $urandom_range(0, 3);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        t_rsp               none_found;
        int                 n;
        none_found = rsp_of(1'b0, '0, '0, '0);

        // empty table: query, delete and spare request codes
        stage_row(REQ_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'hBEEF, 1'b1, none_found);
        stage_row(REQ_DELETE, 16'h7FFF, 16'h8000, 16'h0001, 16'h0001, 1'b1, none_found);
        stage_row(REQ_SPARE,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, none_found);
        // corner points, largest distance
        stage_row(REQ_ADD,    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1,
                  rsp_of(1'b1, 10'd0, 16'hFFFF, '0));
        stage_row(REQ_ADD,    16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b1,
                  rsp_of(1'b1, 10'd1, 16'h0000, '0));
        stage_row(REQ_QUERY,  16'h8000, 16'h8000, 16'h8000, 16'h1111, 1'b1,
                  rsp_of(1'b1, 10'd1, 16'h0000, '0));
        stage_row(REQ_QUERY,  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1,
                  rsp_of(1'b1, 10'd0, 16'hFFFF, '0));
        stage_row(REQ_DELETE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1,
                  rsp_of(1'b1, 10'd0, 16'hFFFF, '0));
        stage_row(REQ_QUERY,  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1,
                  rsp_of(1'b1, 10'd1, 16'h0000, DIST_MAX));
        // freed slot reused, equal points tie to the lower slot
        stage_row(REQ_ADD,    16'h0000, 16'h0000, 16'h0000, 16'h1234, 1'b1,
                  rsp_of(1'b1, 10'd0, 16'h1234, '0));
        stage_row(REQ_ADD,    16'h0000, 16'h0000, 16'h0000, 16'h5678, 1'b1,
                  rsp_of(1'b1, 10'd2, 16'h5678, '0));
        stage_row(REQ_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                  rsp_of(1'b1, 10'd0, 16'h1234, '0));
        stage_row(REQ_DELETE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                  rsp_of(1'b1, 10'd0, 16'h1234, '0));
        stage_row(REQ_SPARE,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                  rsp_of(1'b1, 10'd2, 16'h5678, '0));
        stage_row(REQ_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                  rsp_of(1'b1, 10'd2, 16'h5678, '0));
        stage_row(REQ_ADD,    16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0);
        stage_row(REQ_ADD,    16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0);
        stage_row(REQ_QUERY,  16'h5555, 16'hAAAA, 16'h5555, 16'h0000, 1'b0, '0);
        stage_row(REQ_QUERY,  16'h0001, 16'hFFFF, 16'h0002, 16'h0000, 1'b0, '0);
        // equal distance from two different points
        stage_row(REQ_ADD,    16'h0008, 16'h0000, 16'h0000, 16'h00F0, 1'b0, '0);
        stage_row(REQ_ADD,    16'hFFF8, 16'h0000, 16'h0000, 16'h0F00, 1'b0, '0);
        stage_row(REQ_DELETE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
        stage_row(REQ_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
        stage_row(REQ_DELETE, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0, '0);
        stage_row(REQ_QUERY,  16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, '0);

        do @(posedge clk); while (!rst_n);

        foreach (dir_rows[k]) send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].rsp);
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm = ((n % 200) >= 150) || (n >= RANDOM_ITEMS - 60);
            if (n % 150 == 149) drain_results();
            send_req(random_request(), 1'b0, '0);
        end

        drain_results();
        repeat (TABLE_DEPTH + 16) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
